@@ sv/usd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usd_pkg: shared types and constants of the UTF-8 stream decoder
// Form limits, substitute character, lead byte classifier and the
// command / status groups between controller and datapath.
// ----------------------------------------------------------------------------
package usd_pkg;

  // Width of the unclamped sum of a five byte form
  localparam int unsigned SumW = 28;

  localparam logic [SumW-1:0] Max1 = 28'h000007F;
  localparam logic [SumW-1:0] Max2 = 28'h00007FF;
  localparam logic [SumW-1:0] Max3 = 28'h000FFFF;
  localparam logic [SumW-1:0] Max4 = 28'h01FFFFF;
  localparam logic [SumW-1:0] Lim5 = 28'h1000000;

  localparam logic [23:0] SubstChar  = 24'd63;  // '?'
  localparam logic [7:0]  FollowMask = 8'h7F;

  // Buffer holds up to four pending bytes plus the new one
  localparam int unsigned BufBytes = 5;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture the accepted byte behind the pending ones
    logic step;  // commit one result and drop the bytes it used
  } usd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;      // the oldest pending byte can be judged now
    logic last;      // the result of this step ends the run
    logic out_free;  // output register can take a result
  } usd_status_t;

  // Form length opened by a lead byte, zero for a bad lead
  function automatic logic [2:0] form_len(input logic [7:0] b);
    logic [2:0] n;
    case (b) inside
      [8'h00:8'h7F]: n = 3'd1;
      [8'hC0:8'hDF]: n = 3'd2;
      [8'hE0:8'hEF]: n = 3'd3;
      [8'hF0:8'hF7]: n = 3'd4;
      [8'hF8:8'hFB]: n = 3'd5;
      default:       n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

@@ sv/usd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usd_if: stream channels of the UTF-8 stream decoder
// Byte channel in, code point channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface usd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface usd_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] code_point;
  logic        malformed;
  logic [2:0]  bytes_used;
  logic        last_of_run;
  logic        end_of_text;

  modport source (output valid, output code_point, output malformed, output bytes_used,
                  output last_of_run, output end_of_text, input ready);
  modport sink   (input valid, input code_point, input malformed, input bytes_used,
                  input last_of_run, input end_of_text, output ready);
endinterface

@@ sv/usd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usd_ctrl: sequencing controller of the UTF-8 stream decoder
// Takes one byte, then steps the datapath once per result until the run ends.
// ----------------------------------------------------------------------------
module usd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  usd_pkg::usd_status_t st_i,
  output usd_pkg::usd_cmd_t    cmd_o
);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;

  always_comb begin
    state_d   = state_q;
    ready_d   = ready_q;
    cmd_o     = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i && ready_q) begin
          cmd_o.load = 1'b1;
          state_d    = StRun;
          ready_d    = 1'b0;
        end
      end
      StRun: begin
        if (!st_i.emit) begin
          // byte only extended an unfinished form, or buffer drained
          state_d = StIdle;
          ready_d = 1'b1;
        end else if (st_i.out_free) begin
          cmd_o.step = 1'b1;
          if (st_i.last) begin
            state_d = StIdle;
            ready_d = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
        ready_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  assign in_ready_o = ready_q;

endmodule

@@ sv/usd_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usd_datapath: byte buffer, form decoder and output register
// Judges the form at the oldest pending byte and shifts used bytes out.
// ----------------------------------------------------------------------------
module usd_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  usd_pkg::usd_cmd_t    cmd_i,
  output usd_pkg::usd_status_t st_o,
  input  logic [7:0]           text_byte_i,
  input  logic                 final_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [23:0]          code_point_o,
  output logic                 malformed_o,
  output logic [2:0]           bytes_used_o,
  output logic                 last_of_run_o,
  output logic                 end_of_text_o
);

  localparam int unsigned BufW = 8 * usd_pkg::BufBytes;
  localparam int unsigned SumW = usd_pkg::SumW;

  logic [BufW-1:0] buf_q, buf_d;
  logic [2:0]      cnt_q, cnt_d;
  logic            fin_q;
  logic            vld_q;

  logic [23:0]     cp_q;
  logic            bad_q, last_q, eot_q;
  logic [2:0]      used_q;

  logic [7:0]      b0, b1, b2, b3, b4;
  logic [2:0]      need, used, rem, nlen;
  logic [SumW-1:0] sum;
  logic            fits, ok, good, emit, next_emits;
  logic [BufW-1:0] shifted;

  function automatic logic [SumW-1:0] fol(input logic [7:0] b);
    return SumW'(b & usd_pkg::FollowMask);
  endfunction

  assign b0 = buf_q[7:0];
  assign b1 = buf_q[15:8];
  assign b2 = buf_q[23:16];
  assign b3 = buf_q[31:24];
  assign b4 = buf_q[39:32];

  assign need = usd_pkg::form_len(b0);

  always_comb begin
    sum = '0;
    ok  = 1'b0;
    case (need)
      3'd1: begin
        sum = SumW'(b0);
        ok  = 1'b1;
      end
      3'd2: begin
        sum = (SumW'(b0 & 8'h3F) << 6) + fol(b1);
        ok  = sum > usd_pkg::Max1;
      end
      3'd3: begin
        sum = (SumW'(b0 & 8'h1F) << 12) + (fol(b1) << 6) + fol(b2);
        ok  = sum > usd_pkg::Max2;
      end
      3'd4: begin
        sum = (SumW'(b0 & 8'h0F) << 18) + (fol(b1) << 12) + (fol(b2) << 6) + fol(b3);
        ok  = sum > usd_pkg::Max3;
      end
      3'd5: begin
        sum = (SumW'(b0 & 8'h07) << 24) + (fol(b1) << 18) + (fol(b2) << 12)
            + (fol(b3) << 6) + fol(b4);
        ok  = (sum > usd_pkg::Max4) && (sum < usd_pkg::Lim5);
      end
      default: begin
        sum = '0;
        ok  = 1'b0;
      end
    endcase
  end

  assign fits = (need != 3'd0) && (cnt_q >= need);
  assign good = fits && ok;
  assign emit = (cnt_q != 3'd0) && ((need == 3'd0) || fits || fin_q);
  assign used = good ? need : 3'd1;
  assign rem  = cnt_q - used;

  // look ahead at the byte that leads after this step
  assign shifted    = buf_q >> {used, 3'b000};
  assign nlen       = usd_pkg::form_len(shifted[7:0]);
  assign next_emits = (rem != 3'd0) && ((nlen == 3'd0) || (rem >= nlen) || fin_q);

  assign st_o.emit     = emit;
  assign st_o.last     = !next_emits;
  assign st_o.out_free = !vld_q || out_ready_i;

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      for (int i = 0; i < int'(usd_pkg::BufBytes); i++) begin
        if (cnt_q == 3'(i)) buf_d[8*i +: 8] = text_byte_i;
      end
      cnt_d = cnt_q + 3'd1;
    end else if (cmd_i.step) begin
      buf_d = shifted;
      cnt_d = rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
      vld_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.step) begin
        vld_q <= 1'b1;
      end else if (out_ready_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (cmd_i.load) fin_q <= final_byte_i;
    if (cmd_i.step) begin
      cp_q   <= good ? sum[23:0] : usd_pkg::SubstChar;
      bad_q  <= !good;
      used_q <= used;
      last_q <= !next_emits;
      eot_q  <= !next_emits && fin_q;
    end
  end

  assign out_valid_o   = vld_q;
  assign code_point_o  = cp_q;
  assign malformed_o   = bad_q;
  assign bytes_used_o  = used_q;
  assign last_of_run_o = last_q;
  assign end_of_text_o = eot_q;

  // buffer never holds more than four pending bytes plus one new byte
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd5)
    else $error("byte count out of range");

  // a result only goes into a free output register
  a_step_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (!vld_q || out_ready_i))
    else $error("result overwrote a waiting one");

  // the end of a text leaves the buffer empty
  a_eot_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.step && !next_emits && fin_q) |=> (cnt_q == 3'd0))
    else $error("bytes left after end of text");

  // a rejected form always reports the substitute and one byte
  a_bad_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && bad_q) |-> (used_q == 3'd1 && cp_q == usd_pkg::SubstChar))
    else $error("malformed result with wrong payload");

endmodule

@@ sv/utf8_stream_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder: streaming UTF-8 to code point decoder
// Controller plus datapath, one byte taken per run of results.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one text byte per transaction, final_byte marks the last
//   byte of a text. out_o carries one code point per transaction, with
//   malformed, bytes_used, last_of_run and end_of_text flags.
//   A byte that only extends an unfinished form yields no result; a byte
//   that completes forms, or ends the text, yields one result per form, and
//   a rejected form yields '?' for one byte, the rest being judged again.
// Timing:
//   After a byte is taken the controller steps once per result, of which a
//   byte causes 1 to 5, and goes back to waiting for a byte when it causes
//   none. A new byte is taken only after the run of the last one has ended.
//   The first result is stepped into the output register after the byte's
//   transaction, once that register is free.
//   in_i.ready is high only while the controller waits for a byte.
// Reset:
//   rst_ni clears the pending byte count and the output valid flag.
// Stall:
//   The output register holds a result until out_o.ready; the controller
//   stops stepping meanwhile. The last result of a run may still wait there
//   while the next byte is taken.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
  input  logic  clk_i,
  input  logic  rst_ni,
  usd_in_if.sink    in_i,
  usd_out_if.source out_o
);

  usd_pkg::usd_cmd_t    cmd;
  usd_pkg::usd_status_t st;

  // sequencing: byte intake and one step per result
  usd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  // buffer, decoder and output register
  usd_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .text_byte_i   (in_i.text_byte),
    .final_byte_i  (in_i.final_byte),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .code_point_o  (out_o.code_point),
    .malformed_o   (out_o.malformed),
    .bytes_used_o  (out_o.bytes_used),
    .last_of_run_o (out_o.last_of_run),
    .end_of_text_o (out_o.end_of_text)
  );

endmodule
